// ===== rtl/rdq_pkg.sv =====
// ---------------------------------------------------------------------------
// Ring deque package
// Types and fixed widths shared by the ring deque interfaces and top module.
// ---------------------------------------------------------------------------
`default_nettype none

package rdq_pkg;

  // Fixed field widths of the input and result beats.
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int INDEX_W  = 4;

  // Operation codes carried by an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_READ_ENDS  = 3'd5
  } op_t;

  // Status codes carried by a result beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_FRONT,
    S_LOAD_BACK,
    S_SEARCH,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/rdq_in_if.sv =====
// ---------------------------------------------------------------------------
// Ring deque input channel
// Valid/ready channel carrying one operation and its value per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface rdq_in_if
  import rdq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rdq_out_if.sv =====
// ---------------------------------------------------------------------------
// Ring deque result channel
// Valid/ready channel carrying status, end values, count and search outcome.
// ---------------------------------------------------------------------------
`default_nettype none

interface rdq_out_if
  import rdq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  front_value;
  logic [VALUE_W-1:0]  back_value;
  logic [COUNT_W-1:0]  entry_count;
  logic                found;
  logic [INDEX_W-1:0]  found_index;

  modport source (output valid, output status, output front_value, output back_value,
                  output entry_count, output found, output found_index, input ready);
  modport sink   (input valid, input status, input front_value, input back_value,
                  input entry_count, input found, input found_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/rdq_store.sv =====
// ---------------------------------------------------------------------------
// Ring deque entry store
// Single-port-write, single-port-read memory with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module rdq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/ring_deque_with_search.sv =====
// ---------------------------------------------------------------------------
// Ring deque with search
// Bounded double-ended queue of 32-bit values kept as a ring in one memory,
// with cached end values and a linear search from the front.
// ---------------------------------------------------------------------------
// Flow: pushes, reads of the ends and refused operations pass from idle
// through the result state to the output register; pops that reload an end
// also pass a load state. A search reads one entry per cycle and compares
// it with the key, stopping at the first match or after all held entries.
// One operation in flight: the input is ready only while idle.
// Reset empties the deque; the store is not cleared, as only written entries are read.
`default_nettype none

module ring_deque_with_search
  import rdq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rdq_in_if.sink     in_ch,
  rdq_out_if.source  out_ch
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CAP_X     = (IW+1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);

  // Ring slot of an offset from a base slot, wrapped at the capacity.
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_X) begin
      sum = sum - CAP_X;
    end
    return sum[IW-1:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [IW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [VALUE_W-1:0]  front_val_r, front_val_nxt;
  logic [VALUE_W-1:0]  back_val_r, back_val_nxt;
  logic [VALUE_W-1:0]  key_r, key_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                cmp_valid_r, cmp_valid_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  status_t             status_r, status_nxt;
  logic                found_r, found_nxt;
  logic [IW-1:0]       fidx_r, fidx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;

  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_front_r, out_back_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_found_r;
  logic [INDEX_W-1:0]  out_index_r;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [IW-1:0]       rd_addr;
  logic [VALUE_W-1:0]  rd_data;
  logic [IW-1:0]       push_front_slot;
  logic                full, empty, issue;
  logic [31:0]         count_ext, fidx_ext;

  // Entry store.
  rdq_store #(
    .DEPTH (CAPACITY),
    .AW    (IW),
    .DW    (VALUE_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign full            = (count_r == CAP_C);
  assign empty           = (count_r == '0);
  assign issue           = (rd_idx_r < count_r);
  assign push_front_slot = (front_r == '0) ? LAST_SLOT : front_r - IW'(1);

  // Sequencer: next state, store accesses and result capture.
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    front_val_nxt = front_val_r;
    back_val_nxt  = back_val_r;
    key_nxt       = key_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_idx_nxt   = cmp_idx_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_load      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = push_front_slot;
    rd_addr       = wrap_add(front_r, IW'(rd_idx_r));

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          status_nxt = ST_DONE;
          found_nxt  = 1'b0;
          fidx_nxt   = '0;
          state_nxt  = S_RESULT;
          case (op_t'(in_ch.operation))
            OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en         = 1'b1;
                wr_addr       = push_front_slot;
                front_nxt     = push_front_slot;
                count_nxt     = count_r + CW'(1);
                front_val_nxt = in_ch.value;
                if (empty) begin
                  back_val_nxt = in_ch.value;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = wrap_add(front_r, IW'(count_r));
                count_nxt    = count_r + CW'(1);
                back_val_nxt = in_ch.value;
                if (empty) begin
                  front_val_nxt = in_ch.value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_addr   = wrap_add(front_r, IW'(1));
                front_nxt = wrap_add(front_r, IW'(1));
                count_nxt = count_r - CW'(1);
                if (count_r != CW'(1)) begin
                  state_nxt = S_LOAD_FRONT;
                end
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_addr   = wrap_add(front_r, IW'(count_r - CW'(2)));
                count_nxt = count_r - CW'(1);
                if (count_r != CW'(1)) begin
                  state_nxt = S_LOAD_BACK;
                end
              end
            end
            OP_SEARCH: begin
              key_nxt       = in_ch.value;
              rd_idx_nxt    = '0;
              cmp_valid_nxt = 1'b0;
              state_nxt     = S_SEARCH;
            end
            OP_READ_ENDS: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD_FRONT: begin
        front_val_nxt = rd_data;
        state_nxt     = S_RESULT;
      end
      S_LOAD_BACK: begin
        back_val_nxt = rd_data;
        state_nxt    = S_RESULT;
      end
      S_SEARCH: begin
        // Issue the next read while comparing the entry read last cycle.
        cmp_valid_nxt = issue;
        cmp_idx_nxt   = IW'(rd_idx_r);
        rd_idx_nxt    = rd_idx_r + CW'(issue);
        if (cmp_valid_r && (rd_data == key_r)) begin
          found_nxt = 1'b1;
          fidx_nxt  = cmp_idx_r;
          state_nxt = S_RESULT;
        end else if (!issue && !cmp_valid_r) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_valid_r <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    front_val_r <= front_val_nxt;
    back_val_r  <= back_val_nxt;
    key_r       <= key_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    fidx_r      <= fidx_nxt;
  end

  assign count_ext = 32'(count_r);
  assign fidx_ext  = 32'(fidx_r);

  // Output register; end values read as zero when the deque is empty.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_front_r  <= empty ? '0 : front_val_r;
      out_back_r   <= empty ? '0 : back_val_r;
      out_count_r  <= count_ext[COUNT_W-1:0];
      out_found_r  <= found_r;
      out_index_r  <= fidx_ext[INDEX_W-1:0];
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.back_value  = out_back_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.found_index = out_index_r;

endmodule

`default_nettype wire
